FILE: rtl/ffba_pkg.sv
package ffba_pkg;

    // Request beat
    typedef struct packed {
        logic        action;
        logic [31:0] alloc_size;
        logic [10:0] free_id;
    } t_req;

    // Result beat
    typedef struct packed {
        logic        success;
        logic [31:0] block_start;
    } t_rsp;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_CHK,
        S_F_OWN,
        S_F_CHK,
        S_SH_DN,
        S_SH_UP,
        S_F_PUT,
        S_F_CLR,
        S_RESULT
    } t_state;

endpackage

FILE: rtl/first_fit_block_allocator.sv
// Channel  | Direction | Signals                           | Beat
// request  | in        | i_in_valid, o_in_ready, i_in_data | t_req (action, size, id)
// result   | out       | o_out_valid, i_out_ready, o_out_data | t_rsp, one per allocate
// config   | in        | i_cfg_we, i_cfg_data              | pool_size, no wait
//
// One request at a time, taken only in idle. An allocate walks the segments in order and
// takes the first that fits (a failed result if none fits, it gets no number or it asks
// for zero); when the fit uses up a segment, the later segments shift down.
// A free finds its place and joins there (it is dropped on a bad id or a full store),
// then segments shift down or up, or one new segment is written.
// After reset or a pool_size write, an init state writes the pool; a waiting result stalls the next result.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_REQUESTS  = 1024,
    parameter int FREE_SEGMENTS = 1024,
    parameter int ADDR_BITS     = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_req        i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsp        o_out_data,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);

    localparam int A    = ADDR_BITS;
    localparam int CMPW = (A > 32) ? A : 32;
    localparam int CW   = $clog2(FREE_SEGMENTS + 1);
    localparam int IW   = $clog2(FREE_SEGMENTS);
    localparam int RCW  = $clog2(MAX_REQUESTS + 1);
    localparam int OW   = $clog2(MAX_REQUESTS);
    localparam logic [CMPW-1:0] POOL_RST = CMPW'(32'hFFFF_FFFF);

    // Memories: segment list {first, last} and owner table {valid, start, length}
    logic [2*A-1:0] seg_mem [FREE_SEGMENTS];
    logic [2*A:0]   own_mem [MAX_REQUESTS];

    logic           seg_we;
    logic [IW-1:0]  seg_waddr;
    logic [2*A-1:0] seg_wdata;
    logic [IW-1:0]  seg_raddr;
    logic [2*A-1:0] r_seg_rd;

    logic           own_we;
    logic [OW-1:0]  own_waddr;
    logic [2*A:0]   own_wdata;
    logic [OW-1:0]  own_raddr;
    logic [2*A:0]   r_own_rd;

    always_ff @(posedge i_clk) begin
        if (seg_we) begin
            seg_mem[seg_waddr] <= seg_wdata;
        end
        r_seg_rd <= seg_mem[seg_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (own_we) begin
            own_mem[own_waddr] <= own_wdata;
        end
        r_own_rd <= own_mem[own_raddr];
    end

    // Control and working registers
    t_state         r_state, n_state;
    logic [A-1:0]   r_pool;
    logic [RCW-1:0] r_cnt, n_cnt;
    logic [CW-1:0]  r_seg_count, n_seg_count;
    logic [CW-1:0]  r_idx, n_idx;
    logic [CW-1:0]  r_j, n_j;
    logic [RCW-1:0] r_id, n_id;
    t_req           r_req, n_req;
    logic [A-1:0]   r_lo, n_lo;
    logic [A-1:0]   r_hi, n_hi;
    logic [A-1:0]   r_prev_first, n_prev_first;
    logic [A-1:0]   r_prev_last, n_prev_last;
    logic           r_is_free, n_is_free;
    logic           r_succ, n_succ;
    logic [A-1:0]   r_start, n_start;
    logic           r_out_valid, n_out_valid;
    t_rsp           r_out, n_out;

    logic [CMPW-1:0] cfg_ext;
    logic [A-1:0]    cfg_pool;
    assign cfg_ext  = CMPW'(i_cfg_data);
    assign cfg_pool = cfg_ext[A-1:0];

    // Decoded memory words
    logic [A-1:0]    rd_first, rd_last, seg_len;
    logic [CMPW-1:0] size_ext, start_ext;
    logic [A-1:0]    size_a;
    logic            own_valid;
    logic [A-1:0]    own_start, own_len;
    logic [31:0]     fid_m1, id_m1;
    logic            join_prev, join_next;

    assign rd_first  = r_seg_rd[2*A-1:A];
    assign rd_last   = r_seg_rd[A-1:0];
    assign seg_len   = rd_last - rd_first + A'(1);
    assign size_ext  = CMPW'(r_req.alloc_size);
    assign size_a    = size_ext[A-1:0];
    assign start_ext = CMPW'(r_start);
    assign own_valid = r_own_rd[2*A];
    assign own_start = r_own_rd[2*A-1:A];
    assign own_len   = r_own_rd[A-1:0];
    assign join_prev = (r_idx != '0) && ({1'b0, r_prev_last} + (A+1)'(1) == {1'b0, r_lo});
    assign join_next = (r_idx < r_seg_count) && ({1'b0, r_hi} + (A+1)'(1) == {1'b0, rd_first});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_pool      <= POOL_RST[A-1:0];
            r_cnt       <= '0;
            r_seg_count <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cfg_we) begin
            r_state     <= S_INIT;
            r_pool      <= cfg_pool;
            r_cnt       <= '0;
            r_seg_count <= '0;
            r_out_valid <= n_out_valid;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_seg_count <= n_seg_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_j          <= n_j;
        r_id         <= n_id;
        r_req        <= n_req;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_prev_first <= n_prev_first;
        r_prev_last  <= n_prev_last;
        r_is_free    <= n_is_free;
        r_succ       <= n_succ;
        r_start      <= n_start;
        r_out        <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_seg_count  = r_seg_count;
        n_idx        = r_idx;
        n_j          = r_j;
        n_id         = r_id;
        n_req        = r_req;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_prev_first = r_prev_first;
        n_prev_last  = r_prev_last;
        n_is_free    = r_is_free;
        n_succ       = r_succ;
        n_start      = r_start;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;
        seg_we       = 1'b0;
        seg_waddr    = r_idx[IW-1:0];
        seg_wdata    = r_seg_rd;
        seg_raddr    = r_idx[IW-1:0];
        own_we       = 1'b0;
        own_wdata    = '0;
        fid_m1       = 32'(r_req.free_id) - 32'd1;
        id_m1        = 32'(r_id) - 32'd1;
        own_waddr    = id_m1[OW-1:0];
        own_raddr    = fid_m1[OW-1:0];

        case (r_state)
            // Write the whole pool as the first segment
            S_INIT: begin
                seg_we      = 1'b1;
                seg_waddr   = '0;
                seg_wdata   = {A'(1), r_pool};
                n_seg_count = (r_pool != '0) ? CW'(1) : '0;
                n_state     = S_IDLE;
            end
            // Take a request, number it, mark its own owner entry empty
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_in_data;
                    if (r_cnt < RCW'(MAX_REQUESTS)) begin
                        n_cnt = r_cnt + RCW'(1);
                        n_id  = r_cnt + RCW'(1);
                    end else begin
                        n_id = '0;
                    end
                    id_m1     = 32'(r_cnt);
                    own_waddr = id_m1[OW-1:0];
                    own_we    = (n_id != '0);
                    own_wdata = '0;
                    fid_m1    = 32'(i_in_data.free_id) - 32'd1;
                    own_raddr = fid_m1[OW-1:0];
                    seg_raddr = '0;
                    n_idx     = '0;
                    n_succ    = 1'b0;
                    n_start   = '0;
                    n_is_free = (i_in_data.action == ACT_FREE);
                    if (i_in_data.action == ACT_FREE) begin
                        n_state = S_F_OWN;
                    end else if (n_id == '0 || i_in_data.alloc_size == '0) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_A_CHK;
                    end
                end
            end
            // Walk segments for the first that fits
            S_A_CHK: begin
                if (r_idx >= r_seg_count) begin
                    n_state = S_RESULT;
                end else if (CMPW'(seg_len) >= size_ext) begin
                    n_succ    = 1'b1;
                    n_start   = rd_first;
                    own_we    = 1'b1;
                    own_wdata = {1'b1, rd_first, size_a};
                    if (CMPW'(seg_len) == size_ext) begin
                        seg_raddr = IW'(r_idx + CW'(1));
                        n_state   = S_SH_DN;
                    end else begin
                        seg_we    = 1'b1;
                        seg_wdata = {rd_first + size_a, rd_last};
                        n_state   = S_RESULT;
                    end
                end else begin
                    n_idx     = r_idx + CW'(1);
                    seg_raddr = IW'(r_idx + CW'(1));
                end
            end
            // Check the named allocation is live
            S_F_OWN: begin
                if (r_req.free_id != '0
                    && 32'(r_req.free_id) <= 32'(MAX_REQUESTS)
                    && 32'(r_req.free_id) <= 32'(r_cnt)
                    && 32'(r_req.free_id) != 32'(r_id)
                    && own_valid) begin
                    n_lo      = own_start;
                    n_hi      = own_start + own_len - A'(1);
                    seg_raddr = '0;
                    n_idx     = '0;
                    n_state   = S_F_CHK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            // Find the insert place, then join or insert
            S_F_CHK: begin
                if (r_idx < r_seg_count && rd_first <= r_lo) begin
                    n_prev_first = rd_first;
                    n_prev_last  = rd_last;
                    n_idx        = r_idx + CW'(1);
                    seg_raddr    = IW'(r_idx + CW'(1));
                end else if (join_prev && join_next) begin
                    seg_we    = 1'b1;
                    seg_waddr = IW'(r_idx - CW'(1));
                    seg_wdata = {r_prev_first, rd_last};
                    seg_raddr = IW'(r_idx + CW'(1));
                    n_state   = S_SH_DN;
                end else if (join_prev) begin
                    seg_we    = 1'b1;
                    seg_waddr = IW'(r_idx - CW'(1));
                    seg_wdata = {r_prev_first, r_hi};
                    n_state   = S_F_CLR;
                end else if (join_next) begin
                    seg_we    = 1'b1;
                    seg_wdata = {r_lo, rd_last};
                    n_state   = S_F_CLR;
                end else if (r_seg_count >= CW'(FREE_SEGMENTS)) begin
                    n_state = S_IDLE;
                end else if (r_idx == r_seg_count) begin
                    n_state = S_F_PUT;
                end else begin
                    n_j       = r_seg_count;
                    seg_raddr = IW'(r_seg_count - CW'(1));
                    n_state   = S_SH_UP;
                end
            end
            // Shift segments down over the removed one
            S_SH_DN: begin
                if (r_idx + CW'(1) < r_seg_count) begin
                    seg_we    = 1'b1;
                    seg_wdata = r_seg_rd;
                    n_idx     = r_idx + CW'(1);
                    seg_raddr = IW'(r_idx + CW'(2));
                end else begin
                    n_seg_count = r_seg_count - CW'(1);
                    n_state     = r_is_free ? S_F_CLR : S_RESULT;
                end
            end
            // Shift segments up to open the insert place
            S_SH_UP: begin
                seg_we    = 1'b1;
                seg_waddr = r_j[IW-1:0];
                seg_wdata = r_seg_rd;
                if (r_j - CW'(1) == r_idx) begin
                    n_state = S_F_PUT;
                end else begin
                    n_j       = r_j - CW'(1);
                    seg_raddr = IW'(r_j - CW'(2));
                end
            end
            // Write the new segment
            S_F_PUT: begin
                seg_we      = 1'b1;
                seg_wdata   = {r_lo, r_hi};
                n_seg_count = r_seg_count + CW'(1);
                n_state     = S_F_CLR;
            end
            // Drop the released allocation
            S_F_CLR: begin
                own_we    = 1'b1;
                own_waddr = fid_m1[OW-1:0];
                own_wdata = '0;
                n_state   = S_IDLE;
            end
            // Hand the result to the output register
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.success     = r_succ;
                    n_out.block_start = start_ext[31:0];
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_seg_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg_count <= CW'(FREE_SEGMENTS))
        else $error("segment count above store depth");

    a_req_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= RCW'(MAX_REQUESTS))
        else $error("request counter above limit");

    a_alloc_has_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_CHK) |-> (r_id != '0))
        else $error("search without a request number");

    a_shift_up_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH_UP) |-> (r_j > r_idx))
        else $error("insert shift below insert place");

endmodule
